### src/trg_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoidal reference generator package
// Shared widths, register indexes and reset values of the generator.
// ----------------------------------------------------------------------------
package trg_pkg;

  // default width of the signed reference values
  localparam int VALUE_WIDTH_DEF = 32;

  // configuration register widths
  localparam int VEL_W     = 31;
  localparam int ACC_LIM_W = 31;
  localparam int TS_W      = 16;
  localparam int INV_W     = 32;

  // fraction bits of the tick period; every tick product scales down by this
  localparam int TS_FRAC = TS_W;

  // acceleration state holds at most the limit with a sign
  localparam int ACC_W = ACC_LIM_W + 1;

  // limb width of the shared multiplier
  localparam int LIMB_W = 32;

  // width of the speed limit's square, which is the root's radicand, and of the root
  localparam int VSQ_W  = 2 * VEL_W;
  localparam int ROOT_W = VEL_W;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_VEL = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_ACC = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_INV     = 2'd3;

  // register reset values: 1.0, 1.0, about 0.01 s and 100.0
  localparam logic [VEL_W-1:0]     MAX_VEL_RST = 31'd65536;
  localparam logic [ACC_LIM_W-1:0] MAX_ACC_RST = 31'd65536;
  localparam logic [TS_W-1:0]      STEP_RST    = 16'd655;
  localparam logic [INV_W-1:0]     INV_RST     = 32'd6553600;

endpackage

### src/trapezoidal_reference_generator.sv
// A load word sets the reference; an advance either snaps to the goal or runs
// its products outside or inside the braking zone, the latter with the root.
// Each of up to eight products runs on the one 32x32 multiplier (two limb
// passes); the braking root takes 31 digit steps.
// Throughput: one word at a time; in_tready is high only while idle. Reset (rst_n low,
// synchronous): reference to zero, V = A = 1.0, ts = 655, 1/ts = 100.0, output emptied.
// ----------------------------------------------------------------------------
// Trapezoidal reference generator
// Moves a Q16.16 position reference toward a goal, one tick per advance word,
// within a speed and an acceleration limit, braking along the root profile.
// ----------------------------------------------------------------------------
module trapezoidal_reference_generator #(
  parameter int VALUE_WIDTH = trg_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    in_tdata,  // goal
  input  logic [0:0]                          in_tuser,  // action
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // ref_position, ref_velocity, ref_acceleration, at_goal
  output logic [((3*VALUE_WIDTH+8)/8)*8-1:0]  out_tdata,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [trg_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [trg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int W      = VALUE_WIDTH;
  localparam int ACC_W  = trg_pkg::ACC_W;
  localparam int LW     = trg_pkg::LIMB_W;
  localparam int TSF    = trg_pkg::TS_FRAC;
  localparam int OUT_W  = ((3*VALUE_WIDTH+8)/8)*8;
  localparam int MX_W   = (W > ACC_W) ? W : ACC_W;
  localparam int VSW    = MX_W + 1;
  localparam int PSW    = MX_W + 2;
  localparam int DW     = MX_W + 1;
  localparam int XW     = (W + 2 > DW) ? W + 2 : DW;
  localparam int PW     = ((XW + LW - 1) / LW) * LW + LW;
  localparam int REACH_W = trg_pkg::VEL_W;

  localparam logic signed [VSW-1:0] V_SAT_MAX = $signed({{(VSW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [VSW-1:0] V_SAT_MIN = ~V_SAT_MAX;
  localparam logic signed [PSW-1:0] P_SAT_MAX = $signed({{(PSW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [PSW-1:0] P_SAT_MIN = ~P_SAT_MAX;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_FIX   = 3'd3;
  localparam logic [2:0] ST_SQRT  = 3'd4;
  localparam logic [2:0] ST_DIFF  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  // products on the shared multiplier
  localparam logic [2:0] OP_ADT     = 3'd0;  // a * ts
  localparam logic [2:0] OP_VTS     = 3'd1;  // v' * ts
  localparam logic [2:0] OP_HALF    = 3'd2;  // a*ts * ts, half step
  localparam logic [2:0] OP_REACH_V = 3'd3;  // A * ts
  localparam logic [2:0] OP_REACH_P = 3'd4;  // A*ts * ts, half step
  localparam logic [2:0] OP_VSQ     = 3'd5;  // V * V
  localparam logic [2:0] OP_ERR_A   = 3'd6;  // 2|err| * A
  localparam logic [2:0] OP_RATE    = 3'd7;  // |dv| * (1/ts)

  logic [2:0] state_r;
  logic [2:0] op_r;

  logic [trg_pkg::VEL_W-1:0]     max_vel_r;
  logic [trg_pkg::ACC_LIM_W-1:0] max_acc_r;
  logic [trg_pkg::TS_W-1:0]      step_r;
  logic [trg_pkg::INV_W-1:0]     inv_r;

  logic signed [W-1:0]     pos_r;
  logic signed [W-1:0]     vel_r;
  logic signed [ACC_W-1:0] acc_r;

  logic signed [W-1:0]     goal_r;
  logic signed [ACC_W-1:0] a_dt_r;
  logic signed [W-1:0]     v_r;
  logic signed [W-1:0]     t1_r;
  logic signed [W-1:0]     p_r;
  logic signed [W:0]       err_r;
  logic [REACH_W-1:0]      reach_v_r;
  logic [trg_pkg::VSQ_W-1:0] vsq_r;
  logic [trg_pkg::VEL_W-1:0] mag_r;
  logic signed [DW-1:0]    diff_r;
  logic signed [PW:0]      sh_r;
  logic                    at_goal_r;

  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;

  logic                  in_accept;
  logic                  in_load;
  logic                  send;
  logic                  mul_start;
  logic                  mul_done;
  logic [PW-1:0]         mul_p;
  logic [XW-1:0]         mul_x;
  logic [LW-1:0]         mul_y;
  logic                  mul_neg;
  logic                  sq_start;
  logic                  sq_done;
  logic [trg_pkg::ROOT_W-1:0] sq_root;

  logic [ACC_W-1:0]        acc_mag;
  logic [ACC_W-1:0]        adt_mag;
  logic [W-1:0]            v_mag;
  logic [W:0]              err_mag;
  logic [DW-1:0]           diff_mag;
  logic [PW:0]             p_ext;
  logic signed [PW:0]      sp;
  logic signed [PW:0]      sh_nxt;
  logic signed [ACC_W-1:0] sh_acc;
  logic signed [VSW-1:0]   v_sum;
  logic signed [W-1:0]     v_nxt;
  logic signed [PSW-1:0]   p_sum;
  logic signed [W-1:0]     p_nxt;
  logic signed [W:0]       err_nxt;
  logic [REACH_W-1:0]      reach_p;
  logic                    snap;
  logic                    below;
  logic signed [DW-1:0]    vel_d;
  logic signed [DW-1:0]    diff_nxt;
  logic [PW-TSF-1:0]       rate_q;
  logic [trg_pkg::ACC_LIM_W-1:0] rate;
  logic [ACC_W-1:0]        rate_ext;
  logic signed [ACC_W-1:0] acc_nxt;

  // handshakes
  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign in_load    = in_tuser[0];
  assign send       = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // magnitudes of the signed operands
  always_comb begin
    acc_mag  = acc_r[ACC_W-1]  ? $unsigned(-acc_r)  : $unsigned(acc_r);
    adt_mag  = a_dt_r[ACC_W-1] ? $unsigned(-a_dt_r) : $unsigned(a_dt_r);
    v_mag    = v_r[W-1]        ? $unsigned(-v_r)    : $unsigned(v_r);
    err_mag  = err_r[W]        ? $unsigned(-err_r)  : $unsigned(err_r);
    diff_mag = diff_r[DW-1]    ? $unsigned(-diff_r) : $unsigned(diff_r);
  end

  // select operands and product sign for the current step
  always_comb begin
    mul_x   = '0;
    mul_y   = '0;
    mul_neg = 1'b0;
    unique case (op_r)
      OP_ADT: begin
        mul_x   = XW'(acc_mag);
        mul_y   = LW'(step_r);
        mul_neg = acc_r[ACC_W-1];
      end
      OP_VTS: begin
        mul_x   = XW'(v_mag);
        mul_y   = LW'(step_r);
        mul_neg = v_r[W-1];
      end
      OP_HALF: begin
        mul_x   = XW'(adt_mag);
        mul_y   = LW'(step_r);
        mul_neg = a_dt_r[ACC_W-1];
      end
      OP_REACH_V: begin
        mul_x = XW'(max_acc_r);
        mul_y = LW'(step_r);
      end
      OP_REACH_P: begin
        mul_x = XW'(reach_v_r);
        mul_y = LW'(step_r);
      end
      OP_VSQ: begin
        mul_x = XW'(max_vel_r);
        mul_y = LW'(max_vel_r);
      end
      OP_ERR_A: begin
        mul_x = XW'({err_mag, 1'b0});
        mul_y = LW'(max_acc_r);
      end
      OP_RATE: begin
        mul_x = XW'(diff_mag);
        mul_y = LW'(inv_r);
      end
    endcase
  end

  assign mul_start = (state_r == ST_ISSUE);

  trg_mul #(
    .X_W(XW)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .x      (mul_x),
    .y      (mul_y),
    .done   (mul_done),
    .product(mul_p)
  );

  // apply the sign and scale down, rounding toward minus infinity
  always_comb begin
    p_ext  = {1'b0, mul_p};
    sp     = $signed(mul_neg ? (~p_ext + 1'b1) : p_ext);
    sh_nxt = (op_r == OP_HALF) ? (sp >>> (TSF + 1)) : (sp >>> TSF);
  end

  // integrate velocity and position with saturation
  always_comb begin
    sh_acc = $signed(sh_r[ACC_W-1:0]);
    v_sum  = VSW'(vel_r) + VSW'(sh_acc);
    if (v_sum > V_SAT_MAX) begin
      v_nxt = V_SAT_MAX[W-1:0];
    end else if (v_sum < V_SAT_MIN) begin
      v_nxt = V_SAT_MIN[W-1:0];
    end else begin
      v_nxt = v_sum[W-1:0];
    end
    p_sum = PSW'(pos_r) + PSW'(t1_r) + PSW'(sh_acc);
    if (p_sum > P_SAT_MAX) begin
      p_nxt = P_SAT_MAX[W-1:0];
    end else if (p_sum < P_SAT_MIN) begin
      p_nxt = P_SAT_MIN[W-1:0];
    end else begin
      p_nxt = p_sum[W-1:0];
    end
    err_nxt = (W+1)'(p_r) - (W+1)'(goal_r);
  end

  // stop window, braking zone test, velocity error and limited rate
  always_comb begin
    reach_p  = mul_p[TSF+1 +: REACH_W];
    snap     = (v_mag <= reach_v_r) && (err_mag <= reach_p);
    below    = mul_p < PW'(vsq_r);
    vel_d    = err_r[W] ? $signed(DW'(mag_r)) : -$signed(DW'(mag_r));
    diff_nxt = vel_d - DW'(v_r);
    rate_q   = mul_p[PW-1:TSF];
    rate     = (rate_q > (PW-TSF)'(max_acc_r)) ? max_acc_r
                                                : rate_q[trg_pkg::ACC_LIM_W-1:0];
    rate_ext = ACC_W'(rate);
    acc_nxt  = diff_r[DW-1] ? $signed(~rate_ext + 1'b1) : $signed(rate_ext);
  end

  assign sq_start = (state_r == ST_FIX) && (op_r == OP_ERR_A) && below;

  trg_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .radicand(mul_p[trg_pkg::VSQ_W-1:0]),
    .done    (sq_done),
    .root    (sq_root)
  );

  // sequencer, output valid, configuration and reference state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      op_r         <= OP_ADT;
      out_tvalid_r <= 1'b0;
      max_vel_r    <= trg_pkg::MAX_VEL_RST;
      max_acc_r    <= trg_pkg::MAX_ACC_RST;
      step_r       <= trg_pkg::STEP_RST;
      inv_r        <= trg_pkg::INV_RST;
      pos_r        <= '0;
      vel_r        <= '0;
      acc_r        <= '0;
    end else begin
      // take register writes
      if (cfg_valid) begin
        unique case (cfg_addr)
          trg_pkg::CFG_MAX_VEL: max_vel_r <= cfg_data[trg_pkg::VEL_W-1:0];
          trg_pkg::CFG_MAX_ACC: max_acc_r <= cfg_data[trg_pkg::ACC_LIM_W-1:0];
          trg_pkg::CFG_STEP:    step_r    <= cfg_data[trg_pkg::TS_W-1:0];
          trg_pkg::CFG_INV:     inv_r     <= cfg_data[trg_pkg::INV_W-1:0];
        endcase
      end

      // refill on a send, else drop the word once taken
      if (send) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_load) begin
              pos_r   <= $signed(in_tdata[W-1:0]);
              vel_r   <= '0;
              acc_r   <= '0;
              state_r <= ST_OUT;
            end else begin
              op_r    <= OP_ADT;
              state_r <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mul_done) begin
            state_r <= ST_FIX;
          end
        end
        ST_FIX: begin
          unique case (op_r)
            OP_ADT: begin
              op_r    <= OP_VTS;
              state_r <= ST_ISSUE;
            end
            OP_VTS: begin
              op_r    <= OP_HALF;
              state_r <= ST_ISSUE;
            end
            OP_HALF: begin
              op_r    <= OP_REACH_V;
              state_r <= ST_ISSUE;
            end
            OP_REACH_V: begin
              op_r    <= OP_REACH_P;
              state_r <= ST_ISSUE;
            end
            OP_REACH_P: begin
              if (snap) begin
                pos_r   <= goal_r;
                vel_r   <= '0;
                acc_r   <= '0;
                state_r <= ST_OUT;
              end else begin
                op_r    <= OP_VSQ;
                state_r <= ST_ISSUE;
              end
            end
            OP_VSQ: begin
              op_r    <= OP_ERR_A;
              state_r <= ST_ISSUE;
            end
            OP_ERR_A: begin
              state_r <= below ? ST_SQRT : ST_DIFF;
            end
            OP_RATE: begin
              pos_r   <= p_r;
              vel_r   <= v_r;
              acc_r   <= acc_nxt;
              state_r <= ST_OUT;
            end
          endcase
        end
        ST_SQRT: begin
          if (sq_done) begin
            state_r <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          op_r    <= OP_RATE;
          state_r <= ST_ISSUE;
        end
        ST_OUT: begin
          if (send) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // working values of the tick and the result word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      goal_r    <= $signed(in_tdata[W-1:0]);
      at_goal_r <= 1'b0;
    end
    if (state_r == ST_WAIT && mul_done) begin
      sh_r <= sh_nxt;
    end
    if (state_r == ST_FIX) begin
      unique case (op_r)
        OP_ADT: begin
          a_dt_r <= sh_acc;
          v_r    <= v_nxt;
        end
        OP_VTS: begin
          t1_r <= sh_r[W-1:0];
        end
        OP_HALF: begin
          p_r <= p_nxt;
        end
        OP_REACH_V: begin
          reach_v_r <= mul_p[TSF +: REACH_W];
          err_r     <= err_nxt;
        end
        OP_REACH_P: begin
          at_goal_r <= snap;
        end
        OP_VSQ: begin
          vsq_r <= mul_p[trg_pkg::VSQ_W-1:0];
        end
        OP_ERR_A: begin
          if (!below) begin
            mag_r <= max_vel_r;
          end
        end
        OP_RATE: begin
          at_goal_r <= 1'b0;
        end
      endcase
    end
    if (state_r == ST_SQRT && sq_done) begin
      mag_r <= sq_root;
    end
    if (state_r == ST_DIFF) begin
      diff_r <= diff_nxt;
    end
    if (send) begin
      out_tdata_r <= OUT_W'({at_goal_r, $unsigned(W'(acc_r)), $unsigned(vel_r),
                             $unsigned(pos_r)});
    end
  end

endmodule

### src/trg_mul.sv
// ----------------------------------------------------------------------------
// Shared limb-serial multiplier
// Unsigned X_W by LIMB_W product, one 32x32 partial product a cycle, top limb
// first, accumulated by shift and add. Pulses done with the product ready.
// ----------------------------------------------------------------------------
module trg_mul #(
  parameter int X_W = trg_pkg::VALUE_WIDTH_DEF + 2,
  localparam int LIMBS = (X_W + trg_pkg::LIMB_W - 1) / trg_pkg::LIMB_W,
  localparam int P_W = LIMBS * trg_pkg::LIMB_W + trg_pkg::LIMB_W
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [X_W-1:0]            x,
  input  logic [trg_pkg::LIMB_W-1:0] y,
  output logic                      done,
  output logic [P_W-1:0]            product
);

  localparam int LW    = trg_pkg::LIMB_W;
  localparam int XP_W  = LIMBS * LW;
  localparam int PP_W  = 2 * LW;
  localparam int CNT_W = $clog2(LIMBS + 1);

  logic [XP_W-1:0]  x_r;
  logic [LW-1:0]    y_r;
  logic [P_W-1:0]   acc_r;
  logic [P_W-1:0]   acc_nxt;
  logic [PP_W-1:0]  pp;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  // partial product of the top limb, folded into the running sum
  always_comb begin
    pp      = PP_W'(x_r[XP_W-1 -: LW]) * PP_W'(y_r);
    acc_nxt = (acc_r << LW) + P_W'(pp);
  end

  // sequence the limbs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(LIMBS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands and sum
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= XP_W'(x);
      y_r   <= y;
      acc_r <= '0;
    end else if (busy_r) begin
      x_r   <= x_r << LW;
      acc_r <= acc_nxt;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

### src/trg_isqrt.sv
// ----------------------------------------------------------------------------
// Integer square root
// Digit-by-digit floor root of a radicand below 2^62, one result bit a cycle.
// ----------------------------------------------------------------------------
module trg_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [trg_pkg::VSQ_W-1:0]  radicand,
  output logic                       done,
  output logic [trg_pkg::ROOT_W-1:0] root
);

  localparam int RW = trg_pkg::VSQ_W;

  logic [RW-1:0] rem_r;
  logic [RW-1:0] res_r;
  logic [RW-1:0] bit_r;
  logic [RW-1:0] trial;
  logic          busy_r;
  logic          done_r;

  assign trial = res_r + bit_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // one root digit: subtract the trial where it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= radicand;
      res_r <= '0;
      bit_r <= RW'(1) << (RW - 2);
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[trg_pkg::ROOT_W-1:0];

endmodule

### src/trg_check.sv
// ----------------------------------------------------------------------------
// Trapezoidal reference generator checker
// Port-level properties of the generator, bound to the top level.
// ----------------------------------------------------------------------------
module trg_check #(
  parameter int VALUE_WIDTH = trg_pkg::VALUE_WIDTH_DEF,
  localparam int OUT_W = ((3*VALUE_WIDTH+8)/8)*8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  localparam int W = VALUE_WIDTH;

  // reset empties the result channel
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

  // a taken word keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again straight after a word");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result word changed or dropped");

  // a snap to the goal leaves the reference at rest
  a_goal_at_rest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[3*W]) |->
      (out_tdata[W +: W] == '0 && out_tdata[2*W +: W] == '0))
    else $error("at goal with motion left in the reference");

endmodule

bind trapezoidal_reference_generator trg_check #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_trg_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
